// ===== rtl/bvs_pkg.sv =====
// Shared types and constants of the battery voltage supervisor.
`default_nettype none

package bvs_pkg;

    localparam int unsigned CFG_ADDR_W  = 5;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 16;
    localparam int unsigned ADC_FIELD_W = 10;
    localparam int unsigned LEVEL_W     = 10;
    localparam int unsigned DIVIDER_W   = 8;
    localparam int unsigned TICKS_W     = 16;
    localparam int unsigned STATUS_W    = 2;

    localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

    localparam logic [DIVIDER_W-1:0] RESET_SAMPLE_DIVIDER = 8'd2;
    localparam logic [TICKS_W-1:0]   RESET_STARTUP_TICKS  = 16'd260;
    localparam logic [LEVEL_W-1:0]   RESET_SHUTDOWN_LEVEL = 10'd785;
    localparam logic [LEVEL_W-1:0]   RESET_GOOD_LEVEL     = 10'd907;
    localparam logic [LEVEL_W-1:0]   RESET_BAD_LEVEL      = 10'd797;

    typedef enum logic [2:0] {
        REG_SAMPLE_DIVIDER = 3'd0,
        REG_STARTUP_TICKS  = 3'd1,
        REG_SHUTDOWN_LEVEL = 3'd2,
        REG_GOOD_LEVEL     = 3'd3,
        REG_BAD_LEVEL      = 3'd4
    } reg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_BAD  = 2'd0,
        STATUS_WARN = 2'd1,
        STATUS_GOOD = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/bvs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bvs_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/battery_voltage_supervisor.sv =====
// Top level of the battery voltage supervisor: sample ring, running mean and power control.
// Items are registered in stage one, stage two and the output register; one item per cycle
// is taken unless the output stalls. The ring memory is read one stage ahead and written
// back in the loop stage, which updates the running quotient and remainder of the ring sum.
// Reset: all control state and configuration registers return to their defaults at once.
// The ring memory is not swept; a fill count makes entries not written since reset or the
// last clear read as zero, so items are accepted from the first cycle after reset.
`default_nettype none

module battery_voltage_supervisor #(
    parameter int unsigned RING_DEPTH = 128,
    parameter int unsigned ADC_BITS   = 10
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [bvs_pkg::CFG_ADDR_W-1:0]        paddr,
    input  wire logic [bvs_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic      [bvs_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                       pready,

    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [9:0] adc_sample, [15:10] zero
    input  wire logic [bvs_pkg::IN_TDATA_W-1:0]        s_axis_tdata,

    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [9:0] mean_level, [10] power_enable, [12:11] battery_status, [13] ring_cleared,
    // [15:14] zero
    output logic      [bvs_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);

    localparam int unsigned SLOT_W      = $clog2(RING_DEPTH);
    localparam int unsigned FILL_W      = $clog2(RING_DEPTH + 1);
    localparam int unsigned REM_W       = SLOT_W;
    localparam int unsigned QUO_W       = ADC_BITS;
    localparam int unsigned ENTRY_W     = QUO_W + REM_W;
    localparam int unsigned SHIFT       = ADC_BITS + $clog2(RING_DEPTH);
    localparam int unsigned RECIP_W     = ADC_BITS + 1;
    localparam int unsigned PROD_W      = ADC_BITS + RECIP_W;
    localparam int unsigned MUL_W       = ADC_BITS + SLOT_W + 1;
    localparam int unsigned SAMPLE_IN_W =
        (ADC_BITS < bvs_pkg::ADC_FIELD_W) ? ADC_BITS : bvs_pkg::ADC_FIELD_W;
    localparam int unsigned CMP_W       =
        (ADC_BITS > bvs_pkg::LEVEL_W) ? ADC_BITS : bvs_pkg::LEVEL_W;

    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(RECIP_FULL);
    localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(RING_DEPTH - 1);
    localparam logic [FILL_W-1:0]  FULL_FILL  = FILL_W'(RING_DEPTH);
    localparam logic [MUL_W-1:0]   DEPTH_MUL  = MUL_W'(RING_DEPTH);
    localparam logic [REM_W+1:0]   DEPTH_REM  = (REM_W + 2)'(RING_DEPTH);

    // Configuration registers.
    logic [bvs_pkg::DIVIDER_W-1:0] divider_reg,  divider_next;
    logic [bvs_pkg::TICKS_W-1:0]   startup_reg,  startup_next;
    logic [bvs_pkg::LEVEL_W-1:0]   shutdown_reg, shutdown_next;
    logic [bvs_pkg::LEVEL_W-1:0]   good_reg,     good_next;
    logic [bvs_pkg::LEVEL_W-1:0]   bad_reg,      bad_next;
    logic                          cfg_write;
    bvs_pkg::reg_index_t           cfg_index;

    // Input-side state.
    logic [bvs_pkg::DIVIDER_W-1:0] decimate_reg, decimate_next;
    logic [bvs_pkg::TICKS_W-1:0]   elapsed_reg,  elapsed_next;
    logic [SLOT_W-1:0]             slot_reg,     slot_next;

    // Loop state.
    logic [QUO_W-1:0]              quo_reg,      quo_next;
    logic [REM_W-1:0]              rem_reg,      rem_next;
    logic [FILL_W-1:0]             fill_reg,     fill_next;
    logic                          powered_reg,  powered_next;

    // Pipeline stages.
    logic                          s1_valid_reg,   s1_valid_next;
    logic [PROD_W-1:0]             s1_prod_reg,    s1_prod_next;
    logic [ADC_BITS-1:0]           s1_sample_reg,  s1_sample_next;
    logic                          s1_store_reg,   s1_store_next;
    logic [SLOT_W-1:0]             s1_slot_reg,    s1_slot_next;
    logic                          s1_started_reg, s1_started_next;

    logic                          s2_valid_reg,   s2_valid_next;
    logic [QUO_W-1:0]              s2_quo_reg,     s2_quo_next;
    logic [REM_W-1:0]              s2_rem_reg,     s2_rem_next;
    logic                          s2_store_reg,   s2_store_next;
    logic [SLOT_W-1:0]             s2_slot_reg,    s2_slot_next;
    logic                          s2_started_reg, s2_started_next;

    logic                          out_valid_reg,  out_valid_next;
    logic [bvs_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // Handshake and datapath nets.
    logic                          in_fire;
    logic                          s1_move;
    logic                          s2_fire;
    logic                          s2_ready;
    logic                          s1_ready;
    logic [ADC_BITS-1:0]           in_sample;
    logic [bvs_pkg::DIVIDER_W-1:0] decimate_inc;
    logic [bvs_pkg::TICKS_W-1:0]   elapsed_inc;
    logic                          in_store;
    logic [QUO_W-1:0]              s1_quo;
    logic [MUL_W-1:0]              s1_rem_full;
    logic [ENTRY_W-1:0]            ram_rd_data;
    logic                          old_valid;
    logic [QUO_W-1:0]              old_quo;
    logic [REM_W-1:0]              old_rem;
    logic [REM_W+1:0]              rem_sum;
    logic [QUO_W-1:0]              quo_sum;
    logic [QUO_W-1:0]              quo_upd;
    logic [REM_W-1:0]              rem_upd;
    logic [QUO_W-1:0]              mean;
    logic [CMP_W-1:0]              mean_cmp;
    logic                          power_on;
    logic                          cleared;
    bvs_pkg::status_t              status;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = bvs_pkg::reg_index_t'(paddr[4:2]);

    always_comb
    begin
        divider_next  = divider_reg;
        startup_next  = startup_reg;
        shutdown_next = shutdown_reg;
        good_next     = good_reg;
        bad_next      = bad_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                bvs_pkg::REG_SAMPLE_DIVIDER: divider_next  = pwdata[bvs_pkg::DIVIDER_W-1:0];
                bvs_pkg::REG_STARTUP_TICKS:  startup_next  = pwdata[bvs_pkg::TICKS_W-1:0];
                bvs_pkg::REG_SHUTDOWN_LEVEL: shutdown_next = pwdata[bvs_pkg::LEVEL_W-1:0];
                bvs_pkg::REG_GOOD_LEVEL:     good_next     = pwdata[bvs_pkg::LEVEL_W-1:0];
                bvs_pkg::REG_BAD_LEVEL:      bad_next      = pwdata[bvs_pkg::LEVEL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            bvs_pkg::REG_SAMPLE_DIVIDER: prdata = bvs_pkg::CFG_DATA_W'(divider_reg);
            bvs_pkg::REG_STARTUP_TICKS:  prdata = bvs_pkg::CFG_DATA_W'(startup_reg);
            bvs_pkg::REG_SHUTDOWN_LEVEL: prdata = bvs_pkg::CFG_DATA_W'(shutdown_reg);
            bvs_pkg::REG_GOOD_LEVEL:     prdata = bvs_pkg::CFG_DATA_W'(good_reg);
            bvs_pkg::REG_BAD_LEVEL:      prdata = bvs_pkg::CFG_DATA_W'(bad_reg);
            default:                     prdata = '0;
        endcase
    end

    // Handshakes: each stage moves when the stage after it has room.
    assign s2_fire       = s2_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s2_ready      = !s2_valid_reg || s2_fire;
    assign s1_move       = s1_valid_reg && s2_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Input stage: decimation, tick count and slot assignment.
    assign in_sample    = ADC_BITS'(s_axis_tdata[SAMPLE_IN_W-1:0]);
    assign decimate_inc = decimate_reg + 1'b1;
    assign elapsed_inc  = (elapsed_reg == bvs_pkg::TICKS_MAX) ? elapsed_reg
                                                              : elapsed_reg + 1'b1;
    assign in_store     = decimate_inc >= divider_reg;

    always_comb
    begin
        decimate_next   = decimate_reg;
        elapsed_next    = elapsed_reg;
        slot_next       = slot_reg;
        s1_prod_next    = s1_prod_reg;
        s1_sample_next  = s1_sample_reg;
        s1_store_next   = s1_store_reg;
        s1_slot_next    = s1_slot_reg;
        s1_started_next = s1_started_reg;
        if (in_fire)
        begin
            elapsed_next    = elapsed_inc;
            decimate_next   = in_store ? '0 : decimate_inc;
            if (in_store)
            begin
                slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
            end
            s1_prod_next    = PROD_W'(in_sample) * PROD_W'(RECIP);
            s1_sample_next  = in_sample;
            s1_store_next   = in_store;
            s1_slot_next    = slot_reg;
            s1_started_next = elapsed_inc > startup_reg;
        end
    end

    assign s1_valid_next = in_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);

    // Second stage: split the sample into quotient and remainder by the ring depth.
    assign s1_quo      = QUO_W'(s1_prod_reg >> SHIFT);
    assign s1_rem_full = MUL_W'(s1_sample_reg) - MUL_W'(s1_quo) * DEPTH_MUL;

    always_comb
    begin
        s2_quo_next     = s2_quo_reg;
        s2_rem_next     = s2_rem_reg;
        s2_store_next   = s2_store_reg;
        s2_slot_next    = s2_slot_reg;
        s2_started_next = s2_started_reg;
        if (s1_move)
        begin
            s2_quo_next     = s1_quo;
            s2_rem_next     = REM_W'(s1_rem_full);
            s2_store_next   = s1_store_reg;
            s2_slot_next    = s1_slot_reg;
            s2_started_next = s1_started_reg;
        end
    end

    assign s2_valid_next = s1_move ? 1'b1 : (s2_fire ? 1'b0 : s2_valid_reg);

    bvs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (s2_fire && s2_store_reg),
        .wr_addr (s2_slot_reg),
        .wr_data ({s2_quo_reg, s2_rem_reg}),
        .rd_en   (s1_move),
        .rd_addr (s1_slot_reg),
        .rd_data (ram_rd_data)
    );

    // Loop stage: the ring sum is kept as quotient and remainder by the ring depth.
    // The slot about to be overwritten holds data only once the ring has filled since
    // the last clear.
    assign old_valid = fill_reg == FULL_FILL;
    assign old_quo   = old_valid ? ram_rd_data[ENTRY_W-1:REM_W] : '0;
    assign old_rem   = old_valid ? ram_rd_data[REM_W-1:0] : '0;
    assign rem_sum   = {2'b00, rem_reg} + {2'b00, s2_rem_reg} - {2'b00, old_rem};
    assign quo_sum   = quo_reg + s2_quo_reg - old_quo;

    always_comb
    begin
        if (rem_sum[REM_W+1])
        begin
            rem_upd = REM_W'(rem_sum + DEPTH_REM);
            quo_upd = quo_sum - 1'b1;
        end
        else if (rem_sum >= DEPTH_REM)
        begin
            rem_upd = REM_W'(rem_sum - DEPTH_REM);
            quo_upd = quo_sum + 1'b1;
        end
        else
        begin
            rem_upd = REM_W'(rem_sum);
            quo_upd = quo_sum;
        end
    end

    assign mean     = s2_store_reg ? quo_upd : quo_reg;
    assign mean_cmp = CMP_W'(mean);
    assign power_on = s2_started_reg && (mean_cmp >= CMP_W'(shutdown_reg));
    assign cleared  = !power_on && (mean_cmp < CMP_W'(shutdown_reg)) && powered_reg;

    always_comb
    begin
        if (mean_cmp >= CMP_W'(good_reg))
        begin
            status = bvs_pkg::STATUS_GOOD;
        end
        else if (mean_cmp >= CMP_W'(bad_reg))
        begin
            status = bvs_pkg::STATUS_WARN;
        end
        else
        begin
            status = bvs_pkg::STATUS_BAD;
        end
    end

    always_comb
    begin
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        fill_next    = fill_reg;
        powered_next = powered_reg;
        if (s2_fire)
        begin
            powered_next = power_on;
            if (cleared)
            begin
                quo_next  = '0;
                rem_next  = '0;
                fill_next = '0;
            end
            else if (s2_store_reg)
            begin
                quo_next  = quo_upd;
                rem_next  = rem_upd;
                fill_next = old_valid ? fill_reg : fill_reg + 1'b1;
            end
        end
    end

    // Output register.
    assign out_valid_next = s2_fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    assign out_data_next  = s2_fire
        ? {2'b00, cleared, status, power_on, bvs_pkg::LEVEL_W'(mean)}
        : out_data_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg   <= bvs_pkg::RESET_SAMPLE_DIVIDER;
            startup_reg   <= bvs_pkg::RESET_STARTUP_TICKS;
            shutdown_reg  <= bvs_pkg::RESET_SHUTDOWN_LEVEL;
            good_reg      <= bvs_pkg::RESET_GOOD_LEVEL;
            bad_reg       <= bvs_pkg::RESET_BAD_LEVEL;
            decimate_reg  <= '0;
            elapsed_reg   <= '0;
            slot_reg      <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            fill_reg      <= '0;
            powered_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            divider_reg   <= divider_next;
            startup_reg   <= startup_next;
            shutdown_reg  <= shutdown_next;
            good_reg      <= good_next;
            bad_reg       <= bad_next;
            decimate_reg  <= decimate_next;
            elapsed_reg   <= elapsed_next;
            slot_reg      <= slot_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            fill_reg      <= fill_next;
            powered_reg   <= powered_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg    <= s1_prod_next;
        s1_sample_reg  <= s1_sample_next;
        s1_store_reg   <= s1_store_next;
        s1_slot_reg    <= s1_slot_next;
        s1_started_reg <= s1_started_next;
        s2_quo_reg     <= s2_quo_next;
        s2_rem_reg     <= s2_rem_next;
        s2_store_reg   <= s2_store_next;
        s2_slot_reg    <= s2_slot_next;
        s2_started_reg <= s2_started_next;
        out_data_reg   <= out_data_next;
    end

endmodule

`default_nettype wire
